[sv/ipv6_prefix_trie_table_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the IPv6 prefix trie table
// Concurrent checks that compile away when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef IPV6_PREFIX_TRIE_TABLE_UNIT_ASSERT_SVH
`define IPV6_PREFIX_TRIE_TABLE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define PTT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("trie table check failed");
`define PTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("trie table check failed");
`else
`define PTT_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define PTT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[sv/ptt_pkg.sv]
// ----------------------------------------------------------------------------
// Trie table package
// Pool sizes, codes and memory entry layouts shared by the trie table files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptt_pkg;

  localparam int NODE_COUNT = 65536;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int FREE_W     = NODE_W + 1;
  localparam int ADDR_BITS  = 128;
  localparam int DEPTH_W    = $clog2(ADDR_BITS + 1);

  localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);
  localparam logic [NODE_W-1:0] NULL_NODE = '0;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_POOL_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic [NODE_W-1:0] c0;
    logic [NODE_W-1:0] c1;
    logic              marked;
  } node_t;

  typedef struct packed {
    logic        direct;
    logic [7:0]  port;
    logic [63:0] hop_high;
    logic [63:0] hop_low;
  } route_t;

endpackage

[sv/ptt_in_if.sv]
// ----------------------------------------------------------------------------
// Trie table request channel
// Valid/ready channel carrying one insert, delete or query word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ptt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [63:0] addr_high;
  logic [63:0] addr_low;
  logic [7:0]  prefix_len;
  logic        is_direct;
  logic [7:0]  port_index;
  logic [63:0] hop_high;
  logic [63:0] hop_low;

  modport source (output valid, action, addr_high, addr_low, prefix_len, is_direct,
                  port_index, hop_high, hop_low, input ready);
  modport sink   (input valid, action, addr_high, addr_low, prefix_len, is_direct,
                  port_index, hop_high, hop_low, output ready);
endinterface

[sv/ptt_out_if.sv]
// ----------------------------------------------------------------------------
// Trie table result channel
// Valid/ready channel carrying one status and lookup word per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ptt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        hit;
  logic        hit_direct;
  logic [7:0]  hit_port;
  logic [63:0] hit_hop_high;
  logic [63:0] hit_hop_low;

  modport source (output valid, status, hit, hit_direct, hit_port, hit_hop_high,
                  hit_hop_low, input ready);
  modport sink   (input valid, status, hit, hit_direct, hit_port, hit_hop_high,
                  hit_hop_low, output ready);
endinterface

[sv/ptt_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/ipv6_prefix_trie_table_unit.sv]
// ----------------------------------------------------------------------------
// IPv6 prefix trie table
// Binary trie over a fixed node pool: route insert, delete and longest match.
// ----------------------------------------------------------------------------
// Usage: a request word on in_ch carries an action (insert, delete or query),
// a 128-bit address or prefix, a prefix length and the route to store. Each
// request returns exactly one word on out_ch with a status and, for queries,
// the deepest matching route.
// The address sits in a shift register and one bit leaves it per cycle while
// the walk goes down; each cycle the node memory is read for one trie level,
// or written for a new node. A request is set up, walks up to 128 levels, a
// query with a hit then reads its route, and the result word is loaded. The
// node memory has one write port and one read port with registered read data.
// One request is in work at a time; in_ch.ready is high only while idle. A
// finished word waits in the output register, so the next request may start
// before it is taken; a new result waits until the receiver takes the old.
// After reset the block clears the root node in S_INIT and then
// raises in_ch.ready. Nodes allocated later are written clean when taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ipv6_prefix_trie_table_unit_assert.svh"

module ipv6_prefix_trie_table_unit import ptt_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  ptt_in_if.sink  in_ch,
  ptt_out_if.source out_ch
);

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_WALK  = 6'b000100,
    S_ALLOC = 6'b001000,
    S_RREAD = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t                 state_r, state_nxt;
  action_t                act_r, act_nxt;
  logic [ADDR_BITS-1:0]   addr_sr_r, addr_sr_nxt;
  logic [DEPTH_W-1:0]     len_r, len_nxt;
  logic [DEPTH_W-1:0]     depth_r, depth_nxt;
  logic [NODE_W-1:0]      node_r, node_nxt;
  logic [NODE_W-1:0]      best_r, best_nxt;
  logic                   found_r, found_nxt;
  logic [FREE_W-1:0]      free_r, free_nxt;
  route_t                 route_r, route_nxt;
  status_t                res_status_r, res_status_nxt;
  logic                   res_hit_r, res_hit_nxt;
  route_t                 res_route_r, res_route_nxt;
  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r, out_status_nxt;
  logic                   out_hit_r, out_hit_nxt;
  route_t                 out_route_r, out_route_nxt;

  logic                   nd_we, nd_re;
  logic [NODE_W-1:0]      nd_waddr, nd_raddr;
  node_t                  nd_wdata, nd_rdata;
  logic                   rt_we, rt_re;
  logic [NODE_W-1:0]      rt_raddr;
  route_t                 rt_rdata;

  logic                   in_fire;
  logic                   cur_bit;
  logic [NODE_W-1:0]      child;
  logic                   at_len;
  logic [DEPTH_W-1:0]     need;
  logic                   pool_ok;
  logic                   found_w;
  logic [NODE_W-1:0]      best_w;
  logic [FREE_W-1:0]      free_inc;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign cur_bit  = addr_sr_r[ADDR_BITS-1];
  assign child    = cur_bit ? nd_rdata.c1 : nd_rdata.c0;
  assign at_len   = (depth_r == len_r);
  assign need     = len_r - depth_r;
  assign free_inc = free_r + FREE_W'(1);
  // Every node still missing on the path is taken from the pool in one run.
  assign pool_ok  = ({1'b0, free_r} + (FREE_W+1)'(need)) <= (FREE_W+1)'(NODE_COUNT);
  assign found_w  = found_r || nd_rdata.marked;
  assign best_w   = nd_rdata.marked ? node_r : best_r;

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    addr_sr_nxt    = addr_sr_r;
    len_nxt        = len_r;
    depth_nxt      = depth_r;
    node_nxt       = node_r;
    best_nxt       = best_r;
    found_nxt      = found_r;
    free_nxt       = free_r;
    route_nxt      = route_r;
    res_status_nxt = res_status_r;
    res_hit_nxt    = res_hit_r;
    res_route_nxt  = res_route_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_hit_nxt    = out_hit_r;
    out_route_nxt  = out_route_r;
    nd_we          = 1'b0;
    nd_waddr       = node_r;
    nd_wdata       = nd_rdata;
    nd_re          = 1'b0;
    nd_raddr       = child;
    rt_we          = 1'b0;
    rt_re          = 1'b0;
    rt_raddr       = best_w;

    unique case (state_r)
      S_INIT: begin
        nd_we     = 1'b1;
        nd_waddr  = ROOT_NODE;
        nd_wdata  = '0;
        free_nxt  = FREE_W'(2);
        state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (in_fire) begin
          act_nxt        = action_t'(in_ch.action);
          addr_sr_nxt    = {in_ch.addr_high, in_ch.addr_low};
          len_nxt        = (in_ch.prefix_len > 8'(ADDR_BITS)) ? DEPTH_W'(ADDR_BITS)
                                                              : DEPTH_W'(in_ch.prefix_len);
          depth_nxt      = '0;
          node_nxt       = ROOT_NODE;
          best_nxt       = NULL_NODE;
          found_nxt      = 1'b0;
          route_nxt      = '{direct: in_ch.is_direct, port: in_ch.port_index,
                             hop_high: in_ch.hop_high, hop_low: in_ch.hop_low};
          res_status_nxt = STAT_OK;
          res_hit_nxt    = 1'b0;
          res_route_nxt  = '0;
          if (action_t'(in_ch.action) == ACT_NONE) begin
            state_nxt = S_DONE;
          end else begin
            nd_re     = 1'b1;
            nd_raddr  = ROOT_NODE;
            state_nxt = S_WALK;
          end
        end
      end

      S_WALK: begin
        unique case (act_r)
          ACT_QUERY: begin
            found_nxt = found_w;
            best_nxt  = best_w;
            if (depth_r != DEPTH_W'(ADDR_BITS) && child != NULL_NODE) begin
              nd_re       = 1'b1;
              node_nxt    = child;
              depth_nxt   = depth_r + DEPTH_W'(1);
              addr_sr_nxt = {addr_sr_r[ADDR_BITS-2:0], 1'b0};
            end else if (found_w) begin
              rt_re     = 1'b1;
              state_nxt = S_RREAD;
            end else begin
              state_nxt = S_DONE;
            end
          end
          ACT_DELETE: begin
            if (at_len) begin
              nd_we           = 1'b1;
              nd_wdata.marked = 1'b0;
              state_nxt       = S_DONE;
            end else if (child == NULL_NODE) begin
              res_status_nxt = STAT_NOT_FOUND;
              state_nxt      = S_DONE;
            end else begin
              nd_re       = 1'b1;
              node_nxt    = child;
              depth_nxt   = depth_r + DEPTH_W'(1);
              addr_sr_nxt = {addr_sr_r[ADDR_BITS-2:0], 1'b0};
            end
          end
          ACT_INSERT: begin
            if (at_len) begin
              nd_we           = 1'b1;
              nd_wdata.marked = 1'b1;
              rt_we           = 1'b1;
              state_nxt       = S_DONE;
            end else if (child == NULL_NODE) begin
              if (!pool_ok) begin
                res_status_nxt = STAT_POOL_FULL;
                state_nxt      = S_DONE;
              end else begin
                // Hook the first new node under the last existing one.
                nd_we = 1'b1;
                if (cur_bit) begin
                  nd_wdata.c1 = free_r[NODE_W-1:0];
                end else begin
                  nd_wdata.c0 = free_r[NODE_W-1:0];
                end
                node_nxt    = free_r[NODE_W-1:0];
                free_nxt    = free_inc;
                depth_nxt   = depth_r + DEPTH_W'(1);
                addr_sr_nxt = {addr_sr_r[ADDR_BITS-2:0], 1'b0};
                state_nxt   = S_ALLOC;
              end
            end else begin
              nd_re       = 1'b1;
              node_nxt    = child;
              depth_nxt   = depth_r + DEPTH_W'(1);
              addr_sr_nxt = {addr_sr_r[ADDR_BITS-2:0], 1'b0};
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_ALLOC: begin
        // Each new node is written once with its final contents: the next
        // new node is always the following pool entry.
        nd_we    = 1'b1;
        nd_waddr = node_r;
        nd_wdata = '0;
        if (at_len) begin
          nd_wdata.marked = 1'b1;
          rt_we           = 1'b1;
          state_nxt       = S_DONE;
        end else begin
          if (cur_bit) begin
            nd_wdata.c1 = free_r[NODE_W-1:0];
          end else begin
            nd_wdata.c0 = free_r[NODE_W-1:0];
          end
          node_nxt    = free_r[NODE_W-1:0];
          free_nxt    = free_inc;
          depth_nxt   = depth_r + DEPTH_W'(1);
          addr_sr_nxt = {addr_sr_r[ADDR_BITS-2:0], 1'b0};
        end
      end

      S_RREAD: begin
        res_hit_nxt   = 1'b1;
        res_route_nxt = rt_rdata;
        state_nxt     = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_hit_nxt    = res_hit_r;
          out_route_nxt  = res_route_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
      depth_r     <= '0;
      found_r     <= 1'b0;
      free_r      <= FREE_W'(2);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      depth_r     <= depth_nxt;
      found_r     <= found_nxt;
      free_r      <= free_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    addr_sr_r    <= addr_sr_nxt;
    len_r        <= len_nxt;
    node_r       <= node_nxt;
    best_r       <= best_nxt;
    route_r      <= route_nxt;
    res_status_r <= res_status_nxt;
    res_hit_r    <= res_hit_nxt;
    res_route_r  <= res_route_nxt;
    out_status_r <= out_status_nxt;
    out_hit_r    <= out_hit_nxt;
    out_route_r  <= out_route_nxt;
  end

  ptt_ram #(
    .WIDTH($bits(node_t)),
    .DEPTH(NODE_COUNT)
  ) u_node_ram (
    .clk   (clk),
    .we    (nd_we),
    .waddr (nd_waddr),
    .wdata (nd_wdata),
    .re    (nd_re),
    .raddr (nd_raddr),
    .rdata (nd_rdata)
  );

  ptt_ram #(
    .WIDTH($bits(route_t)),
    .DEPTH(NODE_COUNT)
  ) u_route_ram (
    .clk   (clk),
    .we    (rt_we),
    .waddr (node_r),
    .wdata (route_r),
    .re    (rt_re),
    .raddr (rt_raddr),
    .rdata (rt_rdata)
  );

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.hit          = out_hit_r;
  assign out_ch.hit_direct   = out_route_r.direct;
  assign out_ch.hit_port     = out_route_r.port;
  assign out_ch.hit_hop_high = out_route_r.hop_high;
  assign out_ch.hit_hop_low  = out_route_r.hop_low;

  `PTT_ASSERT_IMPLY(a_pool_bound, clk, rst_n, 1'b1, free_r <= FREE_W'(NODE_COUNT))
  `PTT_ASSERT_IMPLY(a_depth_bound, clk, rst_n, 1'b1, depth_r <= DEPTH_W'(ADDR_BITS))
  `PTT_ASSERT_IMPLY(a_alloc_not_null, clk, rst_n, state_r == S_ALLOC, node_r != NULL_NODE)
  `PTT_ASSERT_IMPLY(a_route_read_found, clk, rst_n, state_r == S_RREAD, found_r)
  `PTT_ASSERT_NEXT(a_done_holds_out, clk, rst_n,
                   state_r == S_DONE && out_valid_r && !out_ch.ready, state_r == S_DONE)

endmodule

[dv/tb_ipv6_prefix_trie_table_unit.sv]
// ----------------------------------------------------------------------------
// Trie table testbench
// Drives insert, delete and query words into the trie table. A model of the
// trie, kept in the testbench, predicts each result word. Results are checked
// in order. The run covers the default route, lengths past 128, unused
// actions, a full node pool and a long receiver stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ipv6_prefix_trie_table_unit;
  import ptt_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int QUIET_FROM  = 5000;
  localparam int QUIET_TO    = 12000;
  localparam int HOLD_FROM   = 15000;
  localparam int HOLD_LEN    = 700;

  typedef struct {
    action_t     action;
    logic [127:0] addr;
    logic [7:0]  plen;
    logic        direct;
    logic [7:0]  port;
    logic [63:0] hop_high;
    logic [63:0] hop_low;
  } request_t;

  typedef struct {
    status_t     status;
    logic        hit;
    logic        direct;
    logic [7:0]  port;
    logic [63:0] hop_high;
    logic [63:0] hop_low;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycle_cnt = 0;
  int   fail_cnt = 0;
  bit   in_taken = 1'b0;

  ptt_in_if  in_ch();
  ptt_out_if out_ch();

  ipv6_prefix_trie_table_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #2 clk = ~clk;

  // Trie shadow: node 0 is the null link, node 1 the root.
  logic [15:0]  trie_c0 [NODE_COUNT];
  logic [15:0]  trie_c1 [NODE_COUNT];
  bit           trie_mark [NODE_COUNT];
  logic         trie_direct [NODE_COUNT];
  logic [7:0]   trie_port [NODE_COUNT];
  logic [63:0]  trie_hh [NODE_COUNT];
  logic [63:0]  trie_hl [NODE_COUNT];
  int           free_node = 2;

  request_t pending_words[$];
  answer_t  expected_answers[$];

  // Known prefixes, reused so that inserts, deletes and queries meet.
  logic [127:0] known_addr[$];
  int           known_len[$];

  function automatic logic [15:0] child_of(int node, bit b);
    return b ? trie_c1[node] : trie_c0[node];
  endfunction

  function automatic answer_t lookup_route(request_t r);
    answer_t a;
    int len;
    int node;
    int need;
    int best;
    logic [15:0] c;
    a = '{STAT_OK, 1'b0, 1'b0, 8'd0, 64'd0, 64'd0};
    len = (r.plen > 8'd128) ? 128 : int'(r.plen);
    node = 1;
    case (r.action)
      ACT_INSERT: begin
        need = 0;
        for (int i = 0; i < len; i++) begin
          c = child_of(node, r.addr[127-i]);
          if (c == 0) begin
            need = len - i;
            break;
          end
          node = c;
        end
        if (free_node + need > NODE_COUNT) begin
          a.status = STAT_POOL_FULL;
        end else begin
          node = 1;
          for (int i = 0; i < len; i++) begin
            c = child_of(node, r.addr[127-i]);
            if (c == 0) begin
              c = free_node[15:0];
              free_node++;
              trie_c0[c] = '0;
              trie_c1[c] = '0;
              trie_mark[c] = 1'b0;
              if (r.addr[127-i]) trie_c1[node] = c;
              else trie_c0[node] = c;
            end
            node = c;
          end
          trie_mark[node] = 1'b1;
          trie_direct[node] = r.direct;
          trie_port[node] = r.port;
          trie_hh[node] = r.hop_high;
          trie_hl[node] = r.hop_low;
        end
      end
      ACT_DELETE: begin
        for (int i = 0; i < len; i++) begin
          c = child_of(node, r.addr[127-i]);
          if (c == 0) begin
            a.status = STAT_NOT_FOUND;
            return a;
          end
          node = c;
        end
        trie_mark[node] = 1'b0;
      end
      ACT_QUERY: begin
        best = trie_mark[1] ? 1 : 0;
        for (int i = 0; i < ADDR_BITS; i++) begin
          c = child_of(node, r.addr[127-i]);
          if (c == 0) break;
          node = c;
          if (trie_mark[node]) best = node;
        end
        if (best != 0) begin
          a.hit = 1'b1;
          a.direct = trie_direct[best];
          a.port = trie_port[best];
          a.hop_high = trie_hh[best];
          a.hop_low = trie_hl[best];
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic request_t route_word(action_t act, logic [127:0] addr, int len);
    request_t r;
    r.action = act;
    r.addr = addr;
    r.plen = len[7:0];
    r.direct = 1'($urandom_range(1));
    r.port = 8'($urandom_range(255));
    r.hop_high = {$urandom, $urandom};
    r.hop_low = {$urandom, $urandom};
    return r;
  endfunction

  function automatic logic [127:0] rand_addr();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // Keeps the top len bits of a known prefix and randomizes the rest.
  function automatic logic [127:0] under_prefix(int k);
    logic [127:0] mask;
    mask = ~(128'h0) << (128 - known_len[k]);
    if (known_len[k] == 0) mask = '0;
    return (known_addr[k] & mask) | (rand_addr() & ~mask);
  endfunction

  task automatic push_word(request_t r);
    pending_words.push_back(r);
    if (r.action == ACT_INSERT) begin
      known_addr.push_back(r.addr);
      known_len.push_back((r.plen > 8'd128) ? 128 : int'(r.plen));
    end
  endtask

  function automatic int fresh_len();
    return ($urandom_range(99) < 75) ? $urandom_range(0, 40) : $urandom_range(41, 128);
  endfunction

  task automatic build_directed();
    request_t r;
    push_word(route_word(ACT_QUERY, rand_addr(), 0));
    push_word(route_word(ACT_INSERT, rand_addr(), 0));
    push_word(route_word(ACT_QUERY, rand_addr(), 0));
    r = route_word(ACT_INSERT, ~128'h0, 128);
    r.direct = 1'b1; r.port = 8'hff; r.hop_high = '1; r.hop_low = '1;
    push_word(r);
    r = route_word(ACT_INSERT, 128'h0, 1);
    r.direct = 1'b0; r.port = 8'h00; r.hop_high = '0; r.hop_low = '0;
    push_word(r);
    push_word(route_word(ACT_QUERY, 128'h0, 0));
    push_word(route_word(ACT_QUERY, ~128'h0, 0));
    push_word(route_word(ACT_INSERT, ~128'h0, 128));
    push_word(route_word(ACT_QUERY, ~128'h0, 0));
    // A length above 128 acts as 128.
    push_word(route_word(ACT_DELETE, ~128'h0, 200));
    push_word(route_word(ACT_QUERY, ~128'h0, 0));
    push_word(route_word(ACT_DELETE, 128'h5555 << 100, 64));
    push_word(route_word(ACT_DELETE, ~128'h0, 64));
    push_word(route_word(ACT_INSERT, {64'h0123456789abcdef, 64'h0}, 255));
    push_word(route_word(ACT_QUERY, {64'h0123456789abcdef, 64'h0}, 0));
    push_word(route_word(ACT_NONE, rand_addr(), $urandom_range(255)));
    push_word(route_word(ACT_DELETE, rand_addr(), 0));
    push_word(route_word(ACT_QUERY, ~128'h0, 0));
    push_word(route_word(ACT_DELETE, 128'h0, 1));
    push_word(route_word(ACT_QUERY, 128'h0, 0));
  endtask

  task automatic build_random(int count);
    int pick;
    int k;
    request_t r;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      k = $urandom_range(known_addr.size() - 1);
      if (pick < 35) begin
        if ($urandom_range(99) < 30) r = route_word(ACT_INSERT, known_addr[k], known_len[k]);
        else r = route_word(ACT_INSERT, under_prefix(k), fresh_len());
      end else if (pick < 55) begin
        if ($urandom_range(99) < 75) r = route_word(ACT_DELETE, known_addr[k], known_len[k]);
        else r = route_word(ACT_DELETE, rand_addr(), fresh_len());
      end else if (pick < 90) begin
        r = route_word(ACT_QUERY, under_prefix(k), $urandom_range(255));
      end else begin
        r = route_word(action_t'($urandom_range(3)), rand_addr(), $urandom_range(255));
      end
      push_word(r);
    end
  endtask

  // Full-length inserts of unrelated addresses, enough to run the pool out.
  task automatic build_pool_fill();
    for (int n = 0; n < 560; n++) begin
      push_word(route_word(ACT_INSERT, rand_addr(), 128));
      if (n % 20 == 0) push_word(route_word(ACT_QUERY, under_prefix(known_addr.size() - 1), 0));
    end
    build_random(40);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = ACT_NONE;
    in_ch.addr_high = '0;
    in_ch.addr_low = '0;
    in_ch.prefix_len = '0;
    in_ch.is_direct = 1'b0;
    in_ch.port_index = '0;
    in_ch.hop_high = '0;
    in_ch.hop_low = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < NODE_COUNT; i++) begin
      trie_c0[i] = '0;
      trie_c1[i] = '0;
      trie_mark[i] = 1'b0;
    end
    build_directed();
    build_random(30);
    build_pool_fill();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_words.size() == 0 && !in_ch.valid);
    wait (expected_answers.size() == 0);
    repeat (300) @(posedge clk);
    if (fail_cnt == 0 && expected_answers.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Request driver: a word stays on the bus until it is taken.
  always @(negedge clk) begin
    request_t r;
    bit quiet;
    quiet = cycle_cnt >= QUIET_FROM && cycle_cnt < QUIET_TO;
    if (rst_n && (!in_ch.valid || in_taken)) begin
      if (pending_words.size() > 0 && (quiet || $urandom_range(99) >= 35)) begin
        r = pending_words.pop_front();
        in_ch.action <= r.action;
        in_ch.addr_high <= r.addr[127:64];
        in_ch.addr_low <= r.addr[63:0];
        in_ch.prefix_len <= r.plen;
        in_ch.is_direct <= r.direct;
        in_ch.port_index <= r.port;
        in_ch.hop_high <= r.hop_high;
        in_ch.hop_low <= r.hop_low;
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver, with one long hold so the block backs up.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (cycle_cnt >= HOLD_FROM && cycle_cnt < HOLD_FROM + HOLD_LEN) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= (cycle_cnt >= QUIET_FROM && cycle_cnt < QUIET_TO) ||
                      ($urandom_range(99) >= 35);
    end
  end

  always @(posedge clk) begin
    request_t r;
    answer_t  e;
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      r.action = action_t'(in_ch.action);
      r.addr = {in_ch.addr_high, in_ch.addr_low};
      r.plen = in_ch.prefix_len;
      r.direct = in_ch.is_direct;
      r.port = in_ch.port_index;
      r.hop_high = in_ch.hop_high;
      r.hop_low = in_ch.hop_low;
      expected_answers.push_back(lookup_route(r));
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_answers.size() == 0) begin
        $error("result word with no request outstanding");
        fail_cnt++;
      end else begin
        e = expected_answers.pop_front();
        if (out_ch.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_ch.status);
          fail_cnt++;
        end
        if (out_ch.hit !== e.hit) begin
          $error("hit: expected %0d, got %0d", e.hit, out_ch.hit);
          fail_cnt++;
        end
        if (out_ch.hit_direct !== e.direct) begin
          $error("hit_direct: expected %0d, got %0d", e.direct, out_ch.hit_direct);
          fail_cnt++;
        end
        if (out_ch.hit_port !== e.port) begin
          $error("hit_port: expected %0d, got %0d", e.port, out_ch.hit_port);
          fail_cnt++;
        end
        if (out_ch.hit_hop_high !== e.hop_high) begin
          $error("hit_hop_high: expected %h, got %h", e.hop_high, out_ch.hit_hop_high);
          fail_cnt++;
        end
        if (out_ch.hit_hop_low !== e.hop_low) begin
          $error("hit_hop_low: expected %h, got %h", e.hop_low, out_ch.hit_hop_low);
          fail_cnt++;
        end
      end
    end
  end

endmodule

[sim.f]
+incdir+sv
sv/ptt_pkg.sv
sv/ptt_in_if.sv
sv/ptt_out_if.sv
sv/ptt_ram.sv
sv/ipv6_prefix_trie_table_unit.sv
dv/tb_ipv6_prefix_trie_table_unit.sv
